### hw/rtl/ip_range_table_with_aging_assert.svh
// Assertion macros for the aging range table.
// Expects clk and arst_n in the scope of each use.
`ifndef IP_RANGE_TABLE_WITH_AGING_ASSERT_SVH
`define IP_RANGE_TABLE_WITH_AGING_ASSERT_SVH

// cond_a implies cond_b in the same cycle
`define IPRT_ASSERT_NOW(label, cond_a, cond_b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |-> (cond_b)) \
		else $error("iprt assertion failed");

// cond_a implies cond_b in the next cycle
`define IPRT_ASSERT_NEXT(label, cond_a, cond_b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |=> (cond_b)) \
		else $error("iprt assertion failed");

`endif

### hw/rtl/iprt_pkg.sv
// Shared types, constants and helpers of the aging range table.
// No dependencies.
package iprt_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int REMOVED_W = 11;
	localparam logic [31:0] EXPIRY_RESET = 32'd3600;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_EXPIRE = 2'd3;

	typedef struct packed {
		logic [63:0] lo_upper;
		logic [63:0] lo_lower;
		logic [63:0] hi_upper;
		logic [63:0] hi_lower;
		logic [31:0] stamp;
		logic        ok;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic le128(input logic [63:0] au, input logic [63:0] al,
			input logic [63:0] bu, input logic [63:0] bl);
		return (au < bu) || ((au == bu) && (al <= bl));
	endfunction
endpackage

### hw/rtl/iprt_req_if.sv
// Request channel of the aging range table: valid/ready plus request fields.
// Depends on nothing.
interface iprt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [63:0] addr_lo_upper;
	logic [63:0] addr_lo_lower;
	logic [63:0] addr_hi_upper;
	logic [63:0] addr_hi_lower;
	logic        mark_ok;
	logic [31:0] now;

	modport source (output valid, operation, addr_lo_upper, addr_lo_lower, addr_hi_upper,
		addr_hi_lower, mark_ok, now, input ready);
	modport sink (input valid, operation, addr_lo_upper, addr_lo_lower, addr_hi_upper,
		addr_hi_lower, mark_ok, now, output ready);
endinterface

### hw/rtl/iprt_rsp_if.sv
// Response channel of the aging range table: valid/ready plus result fields.
// Depends on nothing.
interface iprt_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic        entry_ok;
	logic [63:0] match_lo_upper;
	logic [63:0] match_lo_lower;
	logic [63:0] match_hi_upper;
	logic [63:0] match_hi_lower;
	logic [31:0] match_stamp;
	logic [10:0] removed_count;

	modport source (output valid, found, entry_ok, match_lo_upper, match_lo_lower,
		match_hi_upper, match_hi_lower, match_stamp, removed_count, input ready);
	modport sink (input valid, found, entry_ok, match_lo_upper, match_lo_lower,
		match_hi_upper, match_hi_lower, match_stamp, removed_count, output ready);
endinterface

### hw/rtl/ip_range_table_with_aging.sv
// Aging table of 128-bit address ranges with timestamps and ok marks.
// Requests come on req (valid/ready), one result per request leaves on rsp.
// Operations: lookup (first entry holding the address), insert, remove range,
// expire. A deletion moves the last entry into the freed slot, which is
// checked again. Insert removes overlapping entries; on a full table it then
// expires old entries, else evicts the oldest one, then appends.
// One request is in work at a time; req.ready is high only when idle.
// A lookup scans up to the first hit; remove and expire scan the whole table.
// An insert runs one overlap scan, and on a full table an expire scan and
// possibly an evict scan.
// The walk goes one entry at a time through the single read port of the
// entry RAM (registered read).
// Reset empties the table at once; no clearing pass is needed, and
// expiry_age returns to 3600. A stalled rsp holds the result and the block.
// Depends on iprt_pkg, iprt_req_if, iprt_rsp_if, iprt_ram and the assert header.
`include "ip_range_table_with_aging_assert.svh"

module ip_range_table_with_aging import iprt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	iprt_req_if.sink     req,
	iprt_rsp_if.source   rsp,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);
	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_RD      = 9'b000000010,
		ST_CHK     = 9'b000000100,
		ST_MOVE    = 9'b000001000,
		ST_EV_RD   = 9'b000010000,
		ST_EV_CHK  = 9'b000100000,
		ST_EV_MOVE = 9'b001000000,
		ST_APPEND  = 9'b010000000,
		ST_OUT     = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		MODE_LOOKUP,
		MODE_OVERLAP,
		MODE_EXPIRE
	} mode_t;

	state_t               state_q;
	mode_t                mode_q;
	logic [31:0]          expiry_age_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     idx_q;
	logic [IDX_W-1:0]     old_q;
	logic [31:0]          min_stamp_q;
	logic [REMOVED_W-1:0] removed_q;
	logic [REMOVED_W-1:0] base_q;
	logic [1:0]           op_q;
	entry_t               new_q;
	logic [31:0]          cutoff_q;
	logic                 found_q;
	entry_t               match_q;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [IDX_W-1:0]     mem_raddr;
	entry_t               mem_wdata;
	entry_t               rd_entry;
	logic [ENTRY_W-1:0]   rd_bits;

	logic [CNT_W-1:0]     last_cnt;
	logic                 in_table;
	logic                 at_last;
	logic                 hit;
	logic                 full;

	assign rd_entry = entry_t'(rd_bits);
	assign last_cnt = count_q - CNT_W'(1);
	assign in_table = idx_q < count_q;
	assign at_last  = idx_q == last_cnt;
	assign full     = count_q >= CNT_W'(TABLE_DEPTH);

	always_comb begin
		case (mode_q)
			MODE_LOOKUP: hit = le128(rd_entry.lo_upper, rd_entry.lo_lower,
					new_q.lo_upper, new_q.lo_lower) &&
				le128(new_q.lo_upper, new_q.lo_lower, rd_entry.hi_upper, rd_entry.hi_lower);
			MODE_OVERLAP: hit = le128(new_q.lo_upper, new_q.lo_lower,
					rd_entry.hi_upper, rd_entry.hi_lower) &&
				le128(rd_entry.lo_upper, rd_entry.lo_lower, new_q.hi_upper, new_q.hi_lower);
			MODE_EXPIRE: hit = rd_entry.stamp < cutoff_q;
			default: hit = 1'b0;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = rd_entry;
		mem_raddr = idx_q[IDX_W-1:0];
		case (state_q)
			ST_CHK: begin
				if (mode_q != MODE_LOOKUP && hit && !at_last) begin
					mem_raddr = last_cnt[IDX_W-1:0];
				end
			end
			ST_EV_RD: begin
				if (!in_table) begin
					mem_raddr = last_cnt[IDX_W-1:0];
				end
			end
			ST_MOVE: begin
				mem_we = 1'b1;
			end
			ST_EV_MOVE: begin
				mem_we    = 1'b1;
				mem_waddr = old_q;
			end
			ST_APPEND: begin
				mem_we    = !full;
				mem_waddr = count_q[IDX_W-1:0];
				mem_wdata = new_q;
			end
			default: begin
			end
		endcase
	end

	iprt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			expiry_age_q <= EXPIRY_RESET;
			count_q      <= '0;
			mode_q       <= MODE_LOOKUP;
		end else begin
			if (cfg_we) begin
				expiry_age_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q           <= req.operation;
						new_q.lo_upper <= req.addr_lo_upper;
						new_q.lo_lower <= req.addr_lo_lower;
						new_q.hi_upper <= req.addr_hi_upper;
						new_q.hi_lower <= req.addr_hi_lower;
						new_q.stamp    <= req.now;
						new_q.ok       <= req.mark_ok;
						cutoff_q       <= req.now - expiry_age_q;
						idx_q          <= '0;
						removed_q      <= '0;
						found_q        <= 1'b0;
						match_q        <= '0;
						case (req.operation)
							OP_LOOKUP: mode_q <= MODE_LOOKUP;
							OP_EXPIRE: mode_q <= MODE_EXPIRE;
							default:   mode_q <= MODE_OVERLAP;
						endcase
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (in_table) begin
						state_q <= ST_CHK;
					end else if (op_q == OP_INSERT && mode_q == MODE_OVERLAP) begin
						if (full) begin
							mode_q  <= MODE_EXPIRE;
							idx_q   <= '0;
							base_q  <= removed_q;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_APPEND;
						end
					end else if (op_q == OP_INSERT) begin
						// nothing expired: fall back to evicting the oldest
						if (removed_q == base_q) begin
							idx_q   <= '0;
							old_q   <= '0;
							state_q <= ST_EV_RD;
						end else begin
							state_q <= ST_APPEND;
						end
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_CHK: begin
					if (mode_q == MODE_LOOKUP) begin
						if (hit) begin
							found_q <= 1'b1;
							match_q <= rd_entry;
							state_q <= ST_OUT;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= ST_RD;
						end
					end else if (hit) begin
						removed_q <= removed_q + REMOVED_W'(1);
						if (at_last) begin
							count_q <= last_cnt;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_MOVE;
						end
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_MOVE: begin
					// last entry lands in the slot; recheck it
					count_q <= last_cnt;
					state_q <= ST_RD;
				end
				ST_EV_RD: begin
					if (in_table) begin
						state_q <= ST_EV_CHK;
					end else begin
						removed_q <= removed_q + REMOVED_W'(1);
						if (old_q == last_cnt[IDX_W-1:0]) begin
							count_q <= last_cnt;
							state_q <= ST_APPEND;
						end else begin
							state_q <= ST_EV_MOVE;
						end
					end
				end
				ST_EV_CHK: begin
					if (idx_q == '0 || rd_entry.stamp < min_stamp_q) begin
						min_stamp_q <= rd_entry.stamp;
						old_q       <= idx_q[IDX_W-1:0];
					end
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= ST_EV_RD;
				end
				ST_EV_MOVE: begin
					count_q <= last_cnt;
					state_q <= ST_APPEND;
				end
				ST_APPEND: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready          = state_q == ST_IDLE;
	assign rsp.valid          = state_q == ST_OUT;
	assign rsp.found          = found_q;
	assign rsp.entry_ok       = match_q.ok;
	assign rsp.match_lo_upper = match_q.lo_upper;
	assign rsp.match_lo_lower = match_q.lo_lower;
	assign rsp.match_hi_upper = match_q.hi_upper;
	assign rsp.match_hi_lower = match_q.hi_lower;
	assign rsp.match_stamp    = match_q.stamp;
	assign rsp.removed_count  = removed_q;

	`IPRT_ASSERT_NOW(a_count_bound, state_q != ST_IDLE, count_q <= CNT_W'(TABLE_DEPTH))
	`IPRT_ASSERT_NOW(a_write_in_table, mem_we && state_q != ST_APPEND,
		{1'b0, mem_waddr} < {1'b0, count_q})
	`IPRT_ASSERT_NEXT(a_fresh_result, req.valid && req.ready,
		removed_q == '0 && !found_q)
	`IPRT_ASSERT_NOW(a_lookup_no_removal, rsp.valid && op_q == OP_LOOKUP, removed_q == '0)
endmodule

### hw/rtl/iprt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module iprt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### verif/ip_range_table_with_aging_tb.sv
// Self-checking testbench for the aging range table (ip_range_table_with_aging).
// Depends on iprt_pkg, iprt_req_if, iprt_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module ip_range_table_with_aging_tb;
	import iprt_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] lu, ll, hu, hl;
		logic        ok;
		logic [31:0] now;
	} request_t;

	typedef struct packed {
		logic        found, ok;
		logic [63:0] lu, ll, hu, hl;
		logic [31:0] stamp;
		logic [10:0] removed;
	} result_t;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	iprt_req_if req();
	iprt_rsp_if rsp();

	ip_range_table_with_aging dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	request_t    pending_q[$];
	result_t     expected_q[$];
	entry_t      shadow_tbl[TABLE_DEPTH];
	int unsigned shadow_count;
	logic [31:0] shadow_age;
	logic [31:0] clock_now;
	int          errors;
	int          rsp_seen;
	int          idle_cycles;
	int          req_gap;
	int          hold_left;
	bit          long_hold_done;
	bit          req_fire;
	bit          no_idle;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic bit addr_le(input logic [63:0] au, al, bu, bl);
		return {au, al} <= {bu, bl};
	endfunction

	function automatic void drop_entry(input int unsigned i);
		shadow_tbl[i] = shadow_tbl[shadow_count - 1];
		shadow_count--;
	endfunction

	function automatic int unsigned drop_overlaps(input logic [63:0] lu, ll, hu, hl);
		int unsigned n;
		n = 0;
		for (int unsigned i = 0; i < shadow_count; i++)
			while (i < shadow_count &&
					addr_le(lu, ll, shadow_tbl[i].hi_upper, shadow_tbl[i].hi_lower) &&
					addr_le(shadow_tbl[i].lo_upper, shadow_tbl[i].lo_lower, hu, hl)) begin
				drop_entry(i);
				n++;
			end
		return n;
	endfunction

	function automatic int unsigned drop_stale(input logic [31:0] now);
		logic [31:0] cutoff;
		int unsigned n;
		cutoff = now - shadow_age;
		n = 0;
		for (int unsigned i = 0; i < shadow_count; i++)
			while (i < shadow_count && shadow_tbl[i].stamp < cutoff) begin
				drop_entry(i);
				n++;
			end
		return n;
	endfunction

	function automatic void drop_oldest();
		int unsigned oldest;
		oldest = 0;
		if (shadow_count == 0)
			return;
		for (int unsigned i = 1; i < shadow_count; i++)
			if (shadow_tbl[i].stamp < shadow_tbl[oldest].stamp)
				oldest = i;
		drop_entry(oldest);
	endfunction

	function automatic result_t table_response(input request_t r);
		result_t     res;
		int unsigned gone, aged;
		res = '0;
		gone = 0;
		case (r.op)
			OP_LOOKUP: begin
				for (int unsigned i = 0; i < shadow_count; i++)
					if (addr_le(shadow_tbl[i].lo_upper, shadow_tbl[i].lo_lower, r.lu, r.ll) &&
							addr_le(r.lu, r.ll, shadow_tbl[i].hi_upper, shadow_tbl[i].hi_lower)) begin
						res.found = 1'b1;
						res.ok    = shadow_tbl[i].ok;
						res.lu    = shadow_tbl[i].lo_upper;
						res.ll    = shadow_tbl[i].lo_lower;
						res.hu    = shadow_tbl[i].hi_upper;
						res.hl    = shadow_tbl[i].hi_lower;
						res.stamp = shadow_tbl[i].stamp;
						break;
					end
			end
			OP_INSERT: begin
				gone = drop_overlaps(r.lu, r.ll, r.hu, r.hl);
				if (shadow_count >= TABLE_DEPTH) begin
					aged = drop_stale(r.now);
					gone += aged;
					if (aged == 0) begin
						drop_oldest();
						gone++;
					end
				end
				if (shadow_count < TABLE_DEPTH) begin
					shadow_tbl[shadow_count] = '{r.lu, r.ll, r.hu, r.hl, r.now, r.ok};
					shadow_count++;
				end
			end
			OP_REMOVE: gone = drop_overlaps(r.lu, r.ll, r.hu, r.hl);
			default:   gone = drop_stale(r.now);
		endcase
		res.removed = gone[10:0];
		return res;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 64'd0;
			1:       return '1;
			2:       return {$urandom, $urandom};
			3:       return 64'h8000_0000_0000_0000 | 64'($urandom_range(0, 7));
			default: return 64'($urandom_range(0, 40));
		endcase
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       sel;
		logic [63:0] span;
		sel = $urandom_range(0, 99);
		r.op = sel < 40 ? OP_INSERT : sel < 75 ? OP_LOOKUP : sel < 90 ? OP_REMOVE : OP_EXPIRE;
		r.lu = pick_word();
		r.ll = pick_word();
		span = $urandom_range(0, 9) == 0 ? pick_word() : 64'($urandom_range(0, 6));
		if ($urandom_range(0, 9) == 0) begin
			r.hu = pick_word();
			r.hl = pick_word();
		end else begin
			r.hu = r.lu;
			r.hl = r.ll + span;
		end
		r.ok = 1'($urandom);
		if ($urandom_range(0, 19) == 0)
			clock_now = $urandom;
		else
			clock_now += $urandom_range(0, 2500);
		r.now = clock_now;
		return r;
	endfunction

	task automatic queue_request(input logic [1:0] op, input logic [63:0] lu, ll, hu, hl,
			input logic ok, input logic [31:0] now);
		request_t r;
		r = '{op, lu, ll, hu, hl, ok, now};
		pending_q.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || expected_q.size() != 0 || req.valid)
			@(posedge clk);
	endtask

	task automatic write_age(input logic [31:0] age);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= age;
		shadow_age = age;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] age, input int n, input bit burst);
		write_age(age);
		no_idle = burst;
		repeat (n) pending_q.push_back(random_request());
		wait_drained();
	endtask

	// ---------------- request driver ----------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (req.valid && !req_fire) begin
				// hold the offered request
			end else if (req_gap > 0) begin
				req.valid <= 1'b0;
				req_gap--;
			end else if (pending_q.size() != 0) begin
				request_t r;
				r = pending_q.pop_front();
				req.valid         <= 1'b1;
				req.operation     <= r.op;
				req.addr_lo_upper <= r.lu;
				req.addr_lo_lower <= r.ll;
				req.addr_hi_upper <= r.hu;
				req.addr_hi_lower <= r.hl;
				req.mark_ok       <= r.ok;
				req.now           <= r.now;
				if (no_idle || $urandom_range(0, 9) < 6)
					req_gap = 0;
				else
					req_gap = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
						: $urandom_range(1, 4);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// ---------------- response ready ----------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (rsp_seen >= 15 && !long_hold_done) begin
				// long stall: the sender keeps offering and the block backs up
				long_hold_done = 1'b1;
				hold_left = 400;
				rsp.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 49) == 0) begin
				hold_left = $urandom_range(10, 40);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= no_idle || $urandom_range(0, 9) < 7;
			end
		end
	end

	// ---------------- monitor and checker ----------------
	always @(posedge clk) begin
		if (arst_n) begin
			req_fire = req.valid && req.ready;
			if (rsp.valid && rsp.ready) begin
				rsp_seen++;
				if (expected_q.size() == 0) begin
					$error("unexpected response, none pending");
					errors++;
				end else begin
					result_t e;
					e = expected_q.pop_front();
					if (rsp.found !== e.found) begin
						$error("found: expected %0h actual %0h", e.found, rsp.found); errors++;
					end
					if (rsp.entry_ok !== e.ok) begin
						$error("entry_ok: expected %0h actual %0h", e.ok, rsp.entry_ok); errors++;
					end
					if (rsp.match_lo_upper !== e.lu) begin
						$error("match_lo_upper: expected %0h actual %0h", e.lu, rsp.match_lo_upper);
						errors++;
					end
					if (rsp.match_lo_lower !== e.ll) begin
						$error("match_lo_lower: expected %0h actual %0h", e.ll, rsp.match_lo_lower);
						errors++;
					end
					if (rsp.match_hi_upper !== e.hu) begin
						$error("match_hi_upper: expected %0h actual %0h", e.hu, rsp.match_hi_upper);
						errors++;
					end
					if (rsp.match_hi_lower !== e.hl) begin
						$error("match_hi_lower: expected %0h actual %0h", e.hl, rsp.match_hi_lower);
						errors++;
					end
					if (rsp.match_stamp !== e.stamp) begin
						$error("match_stamp: expected %0h actual %0h", e.stamp, rsp.match_stamp);
						errors++;
					end
					if (rsp.removed_count !== e.removed) begin
						$error("removed_count: expected %0d actual %0d", e.removed,
							rsp.removed_count);
						errors++;
					end
				end
			end
			if (req_fire)
				expected_q.push_back(table_response('{req.operation, req.addr_lo_upper,
					req.addr_lo_lower, req.addr_hi_upper, req.addr_hi_lower, req.mark_ok,
					req.now}));
			if (req_fire || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ---------------- test sequence ----------------
	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req.valid         = 1'b0;
		req.operation     = OP_LOOKUP;
		req.addr_lo_upper = '0;
		req.addr_lo_lower = '0;
		req.addr_hi_upper = '0;
		req.addr_hi_lower = '0;
		req.mark_ok       = 1'b0;
		req.now           = '0;
		rsp.ready         = 1'b0;
		errors            = 0;
		rsp_seen          = 0;
		idle_cycles       = 0;
		req_gap           = 0;
		hold_left         = 0;
		long_hold_done    = 1'b0;
		req_fire          = 1'b0;
		no_idle           = 1'b0;
		shadow_count      = 0;
		shadow_age        = EXPIRY_RESET;
		clock_now         = 32'd5000;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset expiry age
		queue_request(OP_LOOKUP, '0, '0, '0, '0, 1'b0, 32'd0);
		queue_request(OP_EXPIRE, '0, '0, '0, '0, 1'b0, 32'd0);
		queue_request(OP_INSERT, '0, '0, '1, '1, 1'b1, 32'd100);
		queue_request(OP_LOOKUP, '0, '0, '0, '0, 1'b0, 32'd100);
		queue_request(OP_LOOKUP, '1, '1, '0, '0, 1'b0, 32'd100);
		queue_request(OP_INSERT, 64'd5, 64'd10, 64'd5, 64'd20, 1'b0, 32'd200);
		queue_request(OP_INSERT, 64'd9, '1, 64'd9, 64'd0, 1'b1, 32'hFFFF_FFFF);
		queue_request(OP_LOOKUP, 64'd9, 64'd7, '0, '0, 1'b0, 32'd0);
		queue_request(OP_INSERT, '1, 64'd0, '1, '1, 1'b1, 32'd4000);
		queue_request(OP_INSERT, 64'd1, 64'd0, 64'd1, 64'd3, 1'b0, 32'd4100);
		queue_request(OP_LOOKUP, '1, 64'h8000_0000_0000_0000, '0, '0, 1'b0, 32'd0);
		queue_request(OP_LOOKUP, 64'd5, 64'd15, '0, '0, 1'b0, 32'd0);
		queue_request(OP_EXPIRE, '0, '0, '0, '0, 1'b0, 32'd3800);
		queue_request(OP_REMOVE, 64'd5, 64'd20, 64'd5, 64'd20, 1'b0, 32'd0);
		queue_request(OP_REMOVE, 64'd3, 64'd0, 64'd2, 64'd0, 1'b0, 32'd0);
		queue_request(OP_REMOVE, '0, '0, '1, '1, 1'b0, 32'd0);
		queue_request(OP_LOOKUP, 64'd1, 64'd2, '0, '0, 1'b0, 32'd0);
		wait_drained();

		run_phase(EXPIRY_RESET, 30, 1'b0);
		run_phase(32'd0, 25, 1'b1);
		run_phase(32'hFFFF_FFFF, 25, 1'b0);
		clock_now = 32'hFFFF_F000;
		run_phase($urandom, 25, 1'b0);
		run_phase(32'd1, 20, 1'b0);

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
